// File: rtl/fcm_pkg.sv
// fcm_pkg: shared types, constants and the format layout for the fat chain manager
// used by fcm_core and fat_chain_manager_unit; no dependencies
package fcm_pkg;

  localparam int NUM_BLOCKS = 1024;
  localparam int FAT_BLOCKS = 2;

  localparam int IDX_W     = $clog2(NUM_BLOCKS);
  localparam int CNT_W     = $clog2(NUM_BLOCKS + 1);
  localparam int ENT_W     = 16;
  localparam int OP_W      = 3;
  localparam int BLK_W     = 10;
  localparam int STAT_W    = 2;
  localparam int CNT_OUT_W = 11;

  localparam logic [ENT_W-1:0] ENDOFCHAIN = 16'h0000;
  localparam logic [ENT_W-1:0] UNUSED     = 16'hFFFF;

  typedef enum logic [OP_W-1:0] {
    OP_FORMAT = 3'd0,
    OP_ALLOC  = 3'd1,
    OP_EXTEND = 3'd2,
    OP_NEXT   = 3'd3,
    OP_FREE   = 3'd4
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    FCM_FMT,
    FCM_IDLE,
    FCM_LOOK,
    FCM_SCAN,
    FCM_LINK,
    FCM_CLAIM,
    FCM_FREE
  } fsm_e;

  typedef struct packed {
    logic             start;
    op_e              op;
    logic [BLK_W-1:0] blk;
  } cmd_t;

  typedef struct packed {
    logic                 done;
    status_e              status;
    logic [BLK_W-1:0]     blk;
    logic                 at_end;
    logic [CNT_OUT_W-1:0] freed;
  } res_t;

  // entry written by a format sweep at a given block index
  function automatic logic [ENT_W-1:0] fmt_entry(input logic [IDX_W-1:0] idx);
    logic [ENT_W-1:0] e;
    int               i;
    i = int'(idx);
    e = UNUSED;
    if (i == 0) begin
      e = ENDOFCHAIN;
    end else if (i < FAT_BLOCKS) begin
      e = ENT_W'(i + 1);
    end else if (i == FAT_BLOCKS) begin
      e = ENDOFCHAIN;
    end else if (i == FAT_BLOCKS + 1) begin
      e = ENDOFCHAIN;
    end
    return e;
  endfunction

endpackage

// File: rtl/fcm_core.sv
// fcm_core: table memory and the sequencer that formats, scans, links and frees
// depends on fcm_pkg
module fcm_core import fcm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  output logic busy_o,
  output res_t res_o
);

  logic [ENT_W-1:0] fat_mem_q [NUM_BLOCKS];

  fsm_e             state_q, state_d;
  op_e              op_q, op_d;
  logic [IDX_W-1:0] blk_q, blk_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] chk_addr_q, chk_addr_d;
  logic             chk_v_q, chk_v_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             report_q, report_d;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  logic [ENT_W-1:0] mem_wdata;
  logic [ENT_W-1:0] rd_raw_q, fwd_data_q, rd_data;
  logic             fwd_hit_q;

  logic             d_unused, d_end, d_link_ok, blk_ok;
  logic             scan_hit, scan_full, fmt_last, free_stop;
  logic [CNT_W-1:0] cnt_inc;

  // read port with write forwarding on the same entry
  assign rd_data   = fwd_hit_q ? fwd_data_q : rd_raw_q;
  assign d_unused  = (rd_data == UNUSED);
  assign d_end     = (rd_data == ENDOFCHAIN);
  assign d_link_ok = (rd_data < ENT_W'(NUM_BLOCKS));
  assign blk_ok    = (int'(cmd_i.blk) < NUM_BLOCKS);
  assign cnt_inc   = cnt_q + CNT_W'(1);
  assign scan_hit  = chk_v_q && d_unused;
  assign scan_full = chk_v_q && !d_unused && (chk_addr_q == IDX_W'(NUM_BLOCKS - 1));
  assign fmt_last  = (idx_q == IDX_W'(NUM_BLOCKS - 1));
  assign free_stop = d_end || !d_link_ok || (cnt_inc == CNT_W'(NUM_BLOCKS));

  assign busy_o = (state_q != FCM_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      FCM_FMT: begin
        if (fmt_last) state_d = FCM_IDLE;
      end
      FCM_IDLE: begin
        if (cmd_i.start) begin
          case (cmd_i.op)
            OP_FORMAT:         state_d = FCM_FMT;
            OP_ALLOC:          state_d = FCM_SCAN;
            OP_EXTEND, OP_NEXT: begin
              if (blk_ok) state_d = FCM_LOOK;
            end
            OP_FREE: begin
              if (blk_ok) state_d = FCM_FREE;
            end
            default:           state_d = FCM_IDLE;
          endcase
        end
      end
      FCM_LOOK: begin
        state_d = (!d_unused && op_q == OP_EXTEND) ? FCM_SCAN : FCM_IDLE;
      end
      FCM_SCAN: begin
        if (scan_hit) begin
          state_d = (op_q == OP_EXTEND) ? FCM_LINK : FCM_CLAIM;
        end else if (scan_full) begin
          state_d = FCM_IDLE;
        end
      end
      FCM_LINK:  state_d = FCM_CLAIM;
      FCM_CLAIM: state_d = FCM_IDLE;
      FCM_FREE: begin
        if (d_unused || free_stop) state_d = FCM_IDLE;
      end
      default:   state_d = FCM_IDLE;
    endcase
  end

  always_comb begin
    op_d       = op_q;
    blk_d      = blk_q;
    idx_d      = idx_q;
    chk_addr_d = chk_addr_q;
    chk_v_d    = chk_v_q;
    cnt_d      = cnt_q;
    report_d   = report_q;
    mem_we     = 1'b0;
    mem_waddr  = idx_q;
    mem_wdata  = UNUSED;
    mem_raddr  = idx_q;
    res_o      = '0;
    res_o.status = ST_OK;
    case (state_q)
      FCM_FMT: begin
        mem_we    = 1'b1;
        mem_wdata = fmt_entry(idx_q);
        idx_d     = idx_q + IDX_W'(1);
        if (fmt_last) res_o.done = report_q;
      end
      FCM_IDLE: begin
        mem_raddr = IDX_W'(cmd_i.blk);
        if (cmd_i.start) begin
          op_d    = cmd_i.op;
          blk_d   = IDX_W'(cmd_i.blk);
          chk_v_d = 1'b0;
          cnt_d   = '0;
          case (cmd_i.op)
            OP_FORMAT: begin
              idx_d    = '0;
              report_d = 1'b1;
            end
            OP_ALLOC: idx_d = '0;
            OP_EXTEND, OP_NEXT, OP_FREE: begin
              idx_d = IDX_W'(cmd_i.blk);
              if (!blk_ok) begin
                res_o.done   = 1'b1;
                res_o.status = ST_BAD;
              end
            end
            default: res_o.done = 1'b1;
          endcase
        end
      end
      FCM_LOOK: begin
        if (d_unused) begin
          res_o.done   = 1'b1;
          res_o.status = ST_BAD;
        end else if (op_q == OP_NEXT) begin
          res_o.done   = 1'b1;
          res_o.at_end = d_end;
          res_o.blk    = d_end ? '0 : rd_data[BLK_W-1:0];
        end else begin
          idx_d   = '0;
          chk_v_d = 1'b0;
        end
      end
      FCM_SCAN: begin
        if (scan_hit) begin
          chk_v_d = 1'b0;
        end else if (scan_full) begin
          res_o.done   = 1'b1;
          res_o.status = ST_FULL;
        end else begin
          chk_v_d    = 1'b1;
          chk_addr_d = idx_q;
          idx_d      = idx_q + IDX_W'(1);
        end
      end
      FCM_LINK: begin
        mem_we    = 1'b1;
        mem_waddr = blk_q;
        mem_wdata = ENT_W'(chk_addr_q);
      end
      FCM_CLAIM: begin
        mem_we     = 1'b1;
        mem_waddr  = chk_addr_q;
        mem_wdata  = ENDOFCHAIN;
        res_o.done = 1'b1;
        res_o.blk  = BLK_W'(chk_addr_q);
      end
      FCM_FREE: begin
        if (d_unused) begin
          res_o.done   = 1'b1;
          res_o.status = (cnt_q == '0) ? ST_BAD : ST_OK;
          res_o.freed  = CNT_OUT_W'(cnt_q);
        end else begin
          mem_we    = 1'b1;
          mem_waddr = idx_q;
          mem_wdata = UNUSED;
          cnt_d     = cnt_inc;
          if (free_stop) begin
            res_o.done  = 1'b1;
            res_o.freed = CNT_OUT_W'(cnt_inc);
          end else begin
            idx_d     = rd_data[IDX_W-1:0];
            mem_raddr = rd_data[IDX_W-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FCM_FMT;
      idx_q     <= '0;
      chk_v_q   <= 1'b0;
      cnt_q     <= '0;
      report_q  <= 1'b0;
      op_q      <= OP_FORMAT;
      fwd_hit_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      chk_v_q   <= chk_v_d;
      cnt_q     <= cnt_d;
      report_q  <= report_d;
      op_q      <= op_d;
      fwd_hit_q <= mem_we && (mem_waddr == mem_raddr);
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q      <= blk_d;
    chk_addr_q <= chk_addr_d;
    fwd_data_q <= mem_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) fat_mem_q[mem_waddr] <= mem_wdata;
    rd_raw_q <= fat_mem_q[mem_raddr];
  end

endmodule

// File: rtl/fat_chain_manager_unit.sv
// fat_chain_manager_unit: top level, command capture and result register
// depends on fcm_pkg and fcm_core
//
// channel   direction  handshake              beat
// command   in         start high, busy low   operation_i, block_i
// result    out        done_o for one cycle   status_o, result_block_o, at_end_o, freed_count_o
//
// a result is registered and shows in the cycle after the sequencer finishes; allocate and
// extend scan the table from block 0 for the lowest free block, one table read a cycle, and
// free walks the chain until its end, a bad link or a free block; format rewrites every entry
// after reset busy stays high during a format sweep of the table memory
// the receiver cannot stall; a new command may be taken while a result is on the ports
module fat_chain_manager_unit import fcm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [OP_W-1:0]      operation_i,
  input  logic [BLK_W-1:0]     block_i,
  output logic                 done_o,
  output logic [STAT_W-1:0]    status_o,
  output logic [BLK_W-1:0]     result_block_o,
  output logic                 at_end_o,
  output logic [CNT_OUT_W-1:0] freed_count_o
);

  cmd_t cmd;
  res_t res;
  logic core_busy;

  logic                 done_q;
  logic [STAT_W-1:0]    status_q;
  logic [BLK_W-1:0]     blk_q;
  logic                 at_end_q;
  logic [CNT_OUT_W-1:0] freed_q;

  assign cmd.start = start && !core_busy;
  assign cmd.op    = op_e'(operation_i);
  assign cmd.blk   = block_i;

  fcm_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .busy_o (core_busy),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= res.done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.done) begin
      status_q <= res.status;
      blk_q    <= res.blk;
      at_end_q <= res.at_end;
      freed_q  <= res.freed;
    end
  end

  assign busy           = core_busy;
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign result_block_o = blk_q;
  assign at_end_o       = at_end_q;
  assign freed_count_o  = freed_q;

  a_accept_progress : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted command neither busy nor answered");

  a_error_fields_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> (result_block_o == '0 && !at_end_o && freed_count_o == '0))
    else $error("error result carries non-zero fields");

  a_end_no_block : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && at_end_o) |-> (result_block_o == '0 && status_o == ST_OK))
    else $error("end of chain result carries a block");

  a_done_after_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy) || $past(busy))
    else $error("result without a command");

endmodule
